FILE: src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check prop at every rising clock edge outside reset
`define ASSERT_CLKD(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check prop at every rising clock edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/scss_pkg.sv
// ---------------------------------------------------------------------------
// scss_pkg
// Types and character constants of the script comment and space stripper.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package scss_pkg;

	typedef enum logic [2:0] {
		MODE_START,
		MODE_SLASH,
		MODE_SPACE,
		MODE_BLOCK,
		MODE_BLOCK_STAR,
		MODE_LINE,
		MODE_STRING,
		MODE_ESCAPE
	} scan_mode_t;

	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} out_item_t;

	typedef struct packed {
		logic      first_vld;
		logic      second_vld;
		out_item_t first;
		out_item_t second;
	} push_t;

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= 8'd9) && (c <= 8'd13));
	endfunction

endpackage

FILE: src/scss_scan.sv
// ---------------------------------------------------------------------------
// scss_scan
// Scan state machine: turns one registered character into zero to two
// result characters and advances the mode and quote delimiter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module scss_scan
	import scss_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_vld,
	input  logic [7:0] item_char,
	output push_t      push
);

	scan_mode_t mode_q, mode_d;
	logic [7:0] delim_q, delim_d;
	push_t      res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_START;
			delim_q <= 8'h00;
		end else if (item_vld) begin
			mode_q  <= mode_d;
			delim_q <= delim_d;
		end
	end

	always_comb begin
		mode_d = mode_q;
		delim_d = delim_q;
		res = '0;
		case (mode_q)
			MODE_START: begin
				if (item_char == CH_SLASH) begin
					mode_d = MODE_SLASH;
				end else begin
					res.first_vld = 1'b1;
					res.first = '{ch: item_char, last: 1'b1};
					if (is_blank(item_char)) begin
						mode_d = MODE_SPACE;
					end else if (item_char inside {CH_DQUOTE, CH_SQUOTE}) begin
						delim_d = item_char;
						mode_d = MODE_STRING;
					end
				end
			end
			MODE_SLASH: begin
				res.first_vld = 1'b1;
				if (item_char == CH_STAR) begin
					mode_d = MODE_BLOCK;
					res.first = '{ch: CH_SPACE, last: 1'b1};
				end else if (item_char == CH_SLASH) begin
					mode_d = MODE_LINE;
					res.first = '{ch: CH_SPACE, last: 1'b1};
				end else begin
					mode_d = MODE_START;
					res.second_vld = 1'b1;
					res.first = '{ch: CH_SLASH, last: 1'b0};
					res.second = '{ch: item_char, last: 1'b1};
				end
			end
			MODE_SPACE: begin
				if (item_char == CH_SLASH) begin
					mode_d = MODE_SLASH;
				end else if (!is_blank(item_char)) begin
					mode_d = MODE_START;
					res.first_vld = 1'b1;
					res.first = '{ch: item_char, last: 1'b1};
				end
			end
			MODE_BLOCK: begin
				if (item_char == CH_STAR) begin
					mode_d = MODE_BLOCK_STAR;
				end
			end
			MODE_BLOCK_STAR: begin
				if (item_char == CH_SLASH) begin
					mode_d = MODE_SPACE;
				end else if (item_char != CH_STAR) begin
					mode_d = MODE_BLOCK;
				end
			end
			MODE_LINE: begin
				if (item_char == CH_NL) begin
					mode_d = MODE_SPACE;
				end
			end
			MODE_STRING: begin
				if (item_char == CH_BSLASH) begin
					mode_d = MODE_ESCAPE;
				end else begin
					res.first_vld = 1'b1;
					res.first = '{ch: item_char, last: 1'b1};
					if (item_char == delim_q) begin
						mode_d = MODE_START;
					end
				end
			end
			MODE_ESCAPE: begin
				mode_d = MODE_STRING;
				res.first_vld = 1'b1;
				res.second_vld = 1'b1;
				res.first = '{ch: CH_BSLASH, last: 1'b0};
				res.second = '{ch: item_char, last: 1'b1};
			end
			default: begin
				mode_d = MODE_START;
			end
		endcase
	end

	// drop results when no character is held
	always_comb begin
		push = res;
		push.first_vld = res.first_vld & item_vld;
		push.second_vld = res.second_vld & item_vld;
	end

endmodule

FILE: src/scss_fifo.sv
// ---------------------------------------------------------------------------
// scss_fifo
// Result queue: takes up to two result characters per cycle and hands
// them out one per request on the output stream.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module scss_fifo
	import scss_pkg::*;
#(
	parameter int unsigned AW = 3
) (
	input  logic          clk,
	input  logic          arst_n,
	input  push_t         push,
	output logic [AW:0]   count,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [7:0]    m_axis_tdata, // [7:0] out_char
	output logic          m_axis_tlast  // last_of_run
);

	out_item_t     mem [1 << AW];
	logic [AW-1:0] wr_q, rd_q, wr_nx;
	logic [AW:0]   count_q;
	logic [1:0]    npush;
	logic          pop;

	assign wr_nx = wr_q + 1'b1;
	assign npush = {1'b0, push.first_vld} + {1'b0, push.second_vld};
	assign pop = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk) begin
		if (push.first_vld) begin
			mem[wr_q] <= push.first;
		end
		if (push.second_vld) begin
			mem[wr_nx] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + AW'(npush);
			rd_q    <= rd_q + AW'(pop);
			count_q <= count_q + (AW + 1)'(npush) - (AW + 1)'(pop);
		end
	end

	assign count = count_q;
	assign m_axis_tvalid = (count_q != '0);
	assign m_axis_tdata = mem[rd_q].ch;
	assign m_axis_tlast = mem[rd_q].last;

endmodule

FILE: src/script_comment_space_stripper.sv
// ---------------------------------------------------------------------------
// script_comment_space_stripper
// Removes comments and collapses whitespace in a script character stream.
// ---------------------------------------------------------------------------
// Input stream s_axis: one source character per request in tdata[7:0].
// Output stream m_axis: one result character per request in tdata[7:0];
// tlast marks the final result caused by one input character. An input
// character causes zero, one or two results.
// A character taken is held in the input register and scanned in the
// next cycle; its results are written into the result queue.
// Throughput: one input character per cycle while the output keeps up;
// the output moves one result per cycle, so items with two results drain
// at half rate and are absorbed by the result queue.
// The input side stalls only when the result queue (1 << FIFO_AW entries)
// could not absorb the results of the held character plus one more.
// When the receiver stalls, results stay queued and tdata/tlast hold;
// input is taken until its count passes DEPTH - 4, then s_axis_tready drops.
// Reset clears the scan mode to start, the quote delimiter to zero and
// empties the queue. A slash still held at end of stream is not flushed.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module script_comment_space_stripper
	import scss_pkg::*;
#(
	parameter int unsigned FIFO_AW = 3
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata, // [7:0] in_char
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata, // [7:0] out_char
	output logic       m_axis_tlast  // last_of_run
);

	localparam int unsigned DEPTH = 1 << FIFO_AW;
	localparam logic [FIFO_AW:0] READY_LIMIT = (FIFO_AW + 1)'(DEPTH - 4);

	logic        vld_s1;
	logic [7:0]  char_s1;
	logic        accept;
	push_t       push;
	logic [FIFO_AW:0] count;

	assign accept = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (count <= READY_LIMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_s1 <= s_axis_tdata;
		end
	end

	scss_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_vld  (vld_s1),
		.item_char (char_s1),
		.push      (push)
	);

	scss_fifo #(
		.AW (FIFO_AW)
	) u_fifo (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.count         (count),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

FILE: src/scss_checker.sv
// ---------------------------------------------------------------------------
// scss_checker
// Port-level checks of the stripper's output stream, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module scss_checker
	import scss_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic       m_axis_tlast
);

	`ASSERT_CLKD(a_valid_holds, clk, arst_n, (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid, "output request dropped while stalled")
	`ASSERT_CLKD(a_data_holds, clk, arst_n, (m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && $stable(m_axis_tlast)), "output payload changed while stalled")
	`ASSERT_ALWAYS(a_idle_in_reset, clk, !arst_n |=> !m_axis_tvalid, "output request during reset")
	`ASSERT_CLKD(a_pair_follows, clk, arst_n, (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid, "second result of a pair missing")
	`ASSERT_CLKD(a_pair_head, clk, arst_n, (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata == CH_SLASH || m_axis_tdata == CH_BSLASH), "unexpected first result of a pair")

endmodule

bind script_comment_space_stripper scss_checker u_scss_checker (.*);
